FILE: src/tbsg_pkg.sv
// Shared types, constants and microcode store for the three-band split gain block.
package tbsg_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int TRACK_W   = 32;
  localparam int COEF_W    = 16;
  localparam int CHAN_W    = 4;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 3;
  localparam int MUL_A_W   = 34;
  localparam int MUL_B_W   = 17;
  localparam int PROD_W    = 51;
  localparam int ACC_W     = 52;
  localparam int RES_W     = 30;

  localparam logic [CHAN_W-1:0] CHANNELS_RST   = 4'd2;
  localparam logic [COEF_W-1:0] SLOW_ALPHA_RST = 16'd1526;
  localparam logic [COEF_W-1:0] FAST_ALPHA_RST = 16'd25684;
  localparam logic [COEF_W-1:0] GAIN_RST       = 16'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNELS   = 3'd0,
    REG_SLOW_ALPHA = 3'd1,
    REG_FAST_ALPHA = 3'd2,
    REG_LOW_GAIN   = 3'd3,
    REG_MID_GAIN   = 3'd4,
    REG_HIGH_GAIN  = 3'd5
  } cfg_reg_t;

  // Sequencer steps
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SLOW   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_FAST   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LOWG   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_MIDG   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_HIGHG  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_FINISH = 3'd6;

  typedef enum logic [2:0] {
    A_DSLOW, A_DFAST, A_LOW, A_MID, A_HIGH
  } a_sel_t;

  typedef enum logic [2:0] {
    B_SLOW_ALPHA, B_FAST_ALPHA, B_LOW_GAIN, B_MID_GAIN, B_HIGH_GAIN
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    J_NEXT, J_ACCEPT, J_OUT
  } jump_t;

  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    logic    mul_en;
    logic    upd_slow;
    logic    upd_fast;
    acc_op_t acc_op;
    logic    finish;
    jump_t   jump;
  } uword_t;

  typedef struct packed {
    logic [COEF_W-1:0] slow_alpha;
    logic [COEF_W-1:0] fast_alpha;
    logic [COEF_W-1:0] low_gain;
    logic [COEF_W-1:0] mid_gain;
    logic [COEF_W-1:0] high_gain;
  } coef_t;

  // Control store: one word per step
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '0;
    w.a_sel  = A_DSLOW;
    w.b_sel  = B_SLOW_ALPHA;
    w.acc_op = ACC_HOLD;
    w.jump   = J_NEXT;
    unique case (step)
      STEP_IDLE: begin
        w.jump = J_ACCEPT;
      end
      STEP_SLOW: begin
        w.a_sel  = A_DSLOW;
        w.b_sel  = B_SLOW_ALPHA;
        w.mul_en = 1'b1;
      end
      STEP_FAST: begin
        w.upd_slow = 1'b1;
        w.a_sel    = A_DFAST;
        w.b_sel    = B_FAST_ALPHA;
        w.mul_en   = 1'b1;
      end
      STEP_LOWG: begin
        w.upd_fast = 1'b1;
        w.a_sel    = A_LOW;
        w.b_sel    = B_LOW_GAIN;
        w.mul_en   = 1'b1;
      end
      STEP_MIDG: begin
        w.acc_op = ACC_LOAD;
        w.a_sel  = A_MID;
        w.b_sel  = B_MID_GAIN;
        w.mul_en = 1'b1;
      end
      STEP_HIGHG: begin
        w.acc_op = ACC_ADD;
        w.a_sel  = A_HIGH;
        w.b_sel  = B_HIGH_GAIN;
        w.mul_en = 1'b1;
      end
      STEP_FINISH: begin
        w.finish = 1'b1;
        w.jump   = J_OUT;
      end
      default: begin
        w.jump = J_NEXT;  // unused step wraps to idle
      end
    endcase
    return w;
  endfunction

endpackage

FILE: src/tbsg_datapath.sv
// Datapath: channel track storage, shared multiplier, accumulator and output rounding.
module tbsg_datapath #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tbsg_pkg::uword_t                     uw,
  input  tbsg_pkg::coef_t                      coef,
  input  logic                                 load,
  input  logic                                 bypass_in,
  input  logic [tbsg_pkg::CHAN_W-1:0]          chan,
  input  logic signed [tbsg_pkg::SAMPLE_W-1:0] sample_in,
  output logic signed [tbsg_pkg::SAMPLE_W-1:0] result
);
  import tbsg_pkg::*;

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic signed [TRACK_W-1:0] slow_mem [MAX_CHANNELS];
  logic signed [TRACK_W-1:0] fast_mem [MAX_CHANNELS];

  logic signed [TRACK_W-1:0] x;
  logic signed [TRACK_W-1:0] slow;
  logic signed [TRACK_W-1:0] fast;
  logic [IDX_W-1:0]          idx;
  logic                      bypass;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;

  logic signed [MUL_A_W-1:0] xe, se, fe;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  rnd;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   total;
  logic signed [RES_W-1:0]   y;
  logic signed [SAMPLE_W-1:0] sat;

  assign xe = {{(MUL_A_W-TRACK_W){x[TRACK_W-1]}}, x};
  assign se = {{(MUL_A_W-TRACK_W){slow[TRACK_W-1]}}, slow};
  assign fe = {{(MUL_A_W-TRACK_W){fast[TRACK_W-1]}}, fast};

  always_comb begin
    unique case (uw.a_sel)
      A_DSLOW: mul_a = xe - se;
      A_DFAST: mul_a = xe - fe;
      A_LOW:   mul_a = se;
      A_MID:   mul_a = fe - se;
      A_HIGH:  mul_a = xe - fe;
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (uw.b_sel)
      B_SLOW_ALPHA: mul_b = {1'b0, coef.slow_alpha};
      B_FAST_ALPHA: mul_b = {1'b0, coef.fast_alpha};
      B_LOW_GAIN:   mul_b = {1'b0, coef.low_gain};
      B_MID_GAIN:   mul_b = {1'b0, coef.mid_gain};
      B_HIGH_GAIN:  mul_b = {1'b0, coef.high_gain};
      default:      mul_b = '0;
    endcase
  end

  // tracker delta: round half up, then drop 16 fraction bits
  assign rnd      = prod + PROD_W'(32768);
  assign prod_ext = {prod[PROD_W-1], prod};
  assign total    = acc + prod_ext + ACC_W'(2097152);
  assign y        = total[ACC_W-1:22];

  always_comb begin
    priority if (y > RES_W'(8388607)) begin
      sat = 24'sh7FFFFF;
    end else if (y < -RES_W'(8388608)) begin
      sat = 24'sh800000;
    end else begin
      sat = y[SAMPLE_W-1:0];
    end
  end

  assign result = bypass ? x[TRACK_W-1:TRACK_W-SAMPLE_W] : sat;

  always_ff @(posedge clk) begin
    if (load) begin
      x      <= {sample_in, 8'd0};
      slow   <= slow_mem[chan[IDX_W-1:0]];
      fast   <= fast_mem[chan[IDX_W-1:0]];
      idx    <= chan[IDX_W-1:0];
      bypass <= bypass_in;
    end else begin
      if (uw.upd_slow) begin
        slow <= slow + rnd[TRACK_W+15:16];
      end
      if (uw.upd_fast) begin
        fast <= fast + rnd[TRACK_W+15:16];
      end
    end
    if (uw.mul_en) begin
      prod <= mul_a * mul_b;
    end
    unique case (uw.acc_op)
      ACC_LOAD: acc <= prod_ext;
      ACC_ADD:  acc <= acc + prod_ext;
      default:  acc <= acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        slow_mem[i] <= '0;
        fast_mem[i] <= '0;
      end
    end else if (uw.finish && !bypass) begin
      slow_mem[idx] <= slow;
      fast_mem[idx] <= fast;
    end
  end

endmodule

FILE: src/three_band_split_gain.sv
// Top level: microcode sequencer, configuration registers and output register.
// Active channel: the item runs through steps slow, fast, low, mid, high gain and finish,
// five products in turn on the single shared 34x17 multiplier; no new item until idle.
// Inactive channel (pass-through): idle goes straight to the finish step.
// A stalled output holds the sequencer in its final step until the output register frees.
// Synchronous reset clears the sequencer, output valid and all channel tracks, and loads the registers' defaults.
module three_band_split_gain #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [tbsg_pkg::CHAN_W-1:0]           chan,
  input  logic signed [tbsg_pkg::SAMPLE_W-1:0]  sample_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [tbsg_pkg::SAMPLE_W-1:0]  sample_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tbsg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tbsg_pkg::COEF_W-1:0]           cfg_data
);
  import tbsg_pkg::*;

  logic [STEP_W-1:0] step, step_next;
  uword_t            uw;
  logic [CHAN_W-1:0] channels_in_use;
  coef_t             coef;
  logic              accept;
  logic              active;
  logic              out_free;
  logic signed [SAMPLE_W-1:0] result;

  assign uw        = ucode(step);
  assign in_stall  = (uw.jump != J_ACCEPT);
  assign accept    = in_valid && !in_stall;
  assign active    = (chan < channels_in_use) && ({1'b0, chan} < 5'(MAX_CHANNELS));
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    unique case (uw.jump)
      J_NEXT:   step_next = step + 3'd1;
      J_ACCEPT: begin
        if (accept) begin
          step_next = active ? STEP_SLOW : STEP_FINISH;
        end else begin
          step_next = step;
        end
      end
      J_OUT:    step_next = out_free ? STEP_IDLE : step;
      default:  step_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.finish && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.finish && out_free) begin
      sample_out <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use <= CHANNELS_RST;
      coef.slow_alpha <= SLOW_ALPHA_RST;
      coef.fast_alpha <= FAST_ALPHA_RST;
      coef.low_gain   <= GAIN_RST;
      coef.mid_gain   <= GAIN_RST;
      coef.high_gain  <= GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CHANNELS:   channels_in_use <= cfg_data[CHAN_W-1:0];
        REG_SLOW_ALPHA: coef.slow_alpha <= cfg_data;
        REG_FAST_ALPHA: coef.fast_alpha <= cfg_data;
        REG_LOW_GAIN:   coef.low_gain   <= cfg_data;
        REG_MID_GAIN:   coef.mid_gain   <= cfg_data;
        REG_HIGH_GAIN:  coef.high_gain  <= cfg_data;
        default: ;  // no register at this index
      endcase
    end
  end

  tbsg_datapath #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .uw        (uw),
    .coef      (coef),
    .load      (accept),
    .bypass_in (!active),
    .chan      (chan),
    .sample_in (sample_in),
    .result    (result)
  );

endmodule

FILE: src/three_band_split_gain_checker.sv
// Port-level checker for three_band_split_gain and its bind.
module three_band_split_gain_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] sample_out
);

  logic [1:0] pend;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 2'd0;
    end else begin
      pend <= pend + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall)
    else $error("item accepted while previous item still in work");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pend != 2'd0)
    else $error("result shown with no item outstanding");

  a_bounded_pend: assert property (@(posedge clk) disable iff (rst)
    pend != 2'd3)
    else $error("more than two items outstanding");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_out))
    else $error("stalled result changed");

endmodule

bind three_band_split_gain three_band_split_gain_checker u_chk (.*);

FILE: test/three_band_split_gain_test.sv
// Self-checking testbench for the three-band split gain block.
module three_band_split_gain_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tbsg_pkg::*;

  localparam int CHANNEL_SLOTS = 8;
  localparam int SETTLE_CYCLES = 10;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASE_ITEMS = 90;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
  localparam logic [COEF_W-1:0] COEF_MAX = 16'hFFFF;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;

  class band_scoreboard;
    logic [CHAN_W-1:0] channels;
    logic [COEF_W-1:0] slow_alpha, fast_alpha, low_gain, mid_gain, high_gain;
    logic signed [TRACK_W-1:0] slow_track[CHANNEL_SLOTS];
    logic signed [TRACK_W-1:0] fast_track[CHANNEL_SLOTS];
    logic signed [SAMPLE_W-1:0] expected_q[$];
    int mismatches;

    function new();
      channels = CHANNELS_RST;
      slow_alpha = SLOW_ALPHA_RST;
      fast_alpha = FAST_ALPHA_RST;
      low_gain = GAIN_RST;
      mid_gain = GAIN_RST;
      high_gain = GAIN_RST;
      foreach (slow_track[i]) begin
        slow_track[i] = '0;
        fast_track[i] = '0;
      end
      mismatches = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
      case (idx)
        REG_CHANNELS:   channels = data[CHAN_W-1:0];
        REG_SLOW_ALPHA: slow_alpha = data;
        REG_FAST_ALPHA: fast_alpha = data;
        REG_LOW_GAIN:   low_gain = data;
        REG_MID_GAIN:   mid_gain = data;
        REG_HIGH_GAIN:  high_gain = data;
        default: ;
      endcase
    endfunction

    // one-pole step, rounding half up
    function logic signed [TRACK_W-1:0] glide(logic signed [TRACK_W-1:0] track, longint x,
                                              logic [COEF_W-1:0] alpha);
      longint prod;
      prod = (x - longint'(track)) * longint'(alpha);
      return TRACK_W'(longint'(track) + ((prod + 32768) >>> 16));
    endfunction

    function void note_input(logic [CHAN_W-1:0] ch, logic signed [SAMPLE_W-1:0] s);
      longint x, low, mid, high, sum, y;
      if (ch >= channels || ch >= CHANNEL_SLOTS) begin
        expected_q.push_back(s);
        return;
      end
      x = longint'(s) * 256;
      slow_track[ch] = glide(slow_track[ch], x, slow_alpha);
      fast_track[ch] = glide(fast_track[ch], x, fast_alpha);
      low = longint'(slow_track[ch]);
      high = x - longint'(fast_track[ch]);
      mid = longint'(fast_track[ch]) - longint'(slow_track[ch]);
      sum = low * longint'(low_gain) + mid * longint'(mid_gain) + high * longint'(high_gain);
      y = (sum + 2097152) >>> 22;
      if (y > longint'(SAMPLE_MAX)) y = longint'(SAMPLE_MAX);
      if (y < longint'(SAMPLE_MIN)) y = longint'(SAMPLE_MIN);
      expected_q.push_back(SAMPLE_W'(y));
    endfunction

    function void check_output(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("sample_out %0d arrived with no item pending", got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("sample_out mismatch: expected %0d, got %0d", want, got);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CHAN_W-1:0] chan = '0;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  band_scoreboard board = new();
  int hold_request = 0;

  three_band_split_gain #(.MAX_CHANNELS(CHANNEL_SLOTS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .chan(chan), .sample_in(sample_in),
    .out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note_input(chan, sample_in);
      if (out_valid && !out_stall) board.check_output(sample_out);
    end
  end

  // receiver back-pressure: random modes, plus long holds on request
  stall_mode_t stall_mode = STALL_NONE;
  int mode_left = 0;
  int hold_left = 0;
  int run_count = 0;

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    run_count++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((run_count % 13) < 5);
      endcase
    end
  end

  task automatic send_item(input logic [CHAN_W-1:0] ch, input logic signed [SAMPLE_W-1:0] s);
    @(negedge clk);
    in_valid <= 1'b1;
    chan <= ch;
    sample_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic rest(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // quiet the sender and wait for every pending result
  task automatic settle();
    rest(1);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [COEF_W-1:0] ch, input logic [COEF_W-1:0] sa,
                               input logic [COEF_W-1:0] fa, input logic [COEF_W-1:0] lg,
                               input logic [COEF_W-1:0] mg, input logic [COEF_W-1:0] hg);
    write_reg(REG_CHANNELS, ch);
    write_reg(REG_SLOW_ALPHA, sa);
    write_reg(REG_FAST_ALPHA, fa);
    write_reg(REG_LOW_GAIN, lg);
    write_reg(REG_MID_GAIN, mg);
    write_reg(REG_HIGH_GAIN, hg);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return SAMPLE_W'($urandom_range(0, 1023) - 512);
      3: return SAMPLE_W'($urandom_range(0, 65535)) - 24'sd32768;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // mostly active channels, some pass-through ones
  function automatic logic [CHAN_W-1:0] pick_chan();
    int active;
    active = (int'(board.channels) > CHANNEL_SLOTS) ? CHANNEL_SLOTS : int'(board.channels);
    if (active == 0 || $urandom_range(0, 4) == 0) return CHAN_W'($urandom_range(0, 15));
    return CHAN_W'($urandom_range(0, active - 1));
  endfunction

  function automatic logic [COEF_W-1:0] rand_gain();
    if ($urandom_range(0, 3) == 0) return COEF_W'($urandom);
    return COEF_W'($urandom_range(4096, 24576));
  endfunction

  // bursts of DC levels, square waves or noise, with random gaps
  task automatic run_phase(input int n);
    int sent, burst, style, gap;
    logic signed [SAMPLE_W-1:0] level;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      style = $urandom_range(0, 3);
      level = rand_sample();
      for (int k = 0; k < burst; k++) begin
        if (style == 0) send_item(pick_chan(), level);
        else if (style == 1) send_item(pick_chan(), k[0] ? level : ~level);
        else send_item(pick_chan(), rand_sample());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) rest(gap);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults: two active channels
    send_item(4'd0, SAMPLE_MAX);
    send_item(4'd0, SAMPLE_MAX);
    send_item(4'd0, SAMPLE_MIN);
    send_item(4'd0, 24'sd0);
    send_item(4'd0, 24'sd1);
    send_item(4'd0, -24'sd1);
    send_item(4'd1, 24'sh555555);
    send_item(4'd1, 24'shAAAAAA);
    send_item(4'd2, SAMPLE_MIN);
    send_item(4'd7, 24'sd123);
    send_item(4'd8, SAMPLE_MAX);
    send_item(4'd15, -24'sd77);
    settle();

    // full alphas and gains, eight channels active: saturation on channels 0 and 7, channel 8 passes through
    apply_setting(COEF_W'(CHANNEL_SLOTS), COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_item(4'd0, SAMPLE_MAX);
    send_item(4'd0, SAMPLE_MIN);
    send_item(4'd7, SAMPLE_MAX);
    send_item(4'd7, SAMPLE_MIN);
    send_item(4'd8, SAMPLE_MIN);
    settle();

    // zero channel count, and writes to unused indexes are dropped
    write_reg(REG_CHANNELS, 16'd0);
    write_reg(REG_SPARE_6, COEF_MAX);
    write_reg(REG_SPARE_7, 16'h1234);
    send_item(4'd0, SAMPLE_MAX);
    send_item(4'd1, -24'sd4096);
    settle();

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: apply_setting(COEF_W'(CHANNELS_RST), SLOW_ALPHA_RST, FAST_ALPHA_RST, GAIN_RST,
                         GAIN_RST, GAIN_RST);
        1: apply_setting(COEF_W'(CHANNEL_SLOTS), COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
                         COEF_MAX);
        2: apply_setting(COEF_W'(CHANNEL_SLOTS), 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        3: apply_setting(16'hFFFF, COEF_W'($urandom), COEF_W'($urandom), rand_gain(),
                         rand_gain(), rand_gain());
        4: apply_setting(16'd1, 16'd1, COEF_MAX, 16'd0, COEF_MAX, 16'd1);
        default: apply_setting(COEF_W'($urandom_range(1, 15)), COEF_W'($urandom),
                               COEF_W'($urandom), rand_gain(), rand_gain(), rand_gain());
      endcase
      if (p == 3) begin
        // long receiver hold while items keep coming
        hold_request = 300;
        for (int k = 0; k < 40; k++) send_item(pick_chan(), rand_sample());
      end
      run_phase(PHASE_ITEMS);
      settle();
    end

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
